### rtl/core/sha1_pkg.sv
// Shared types, constants and helpers for the SHA-1 block hasher.
// Depends on nothing; every other file in rtl/core imports it.
package sha1_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned ROUNDS   = 80;
   localparam int unsigned ROUND_W  = 7;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned WIDX_W   = 4;

   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
   localparam logic [WORD_W-1:0] IV_E = 32'hC3D2E1F0;

   typedef struct packed {
      logic [WORD_W-1:0] message_word;
      logic              final_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_a;
      logic [WORD_W-1:0] digest_b;
      logic [WORD_W-1:0] digest_c;
      logic [WORD_W-1:0] digest_d;
      logic [WORD_W-1:0] digest_e;
   } rsp_type;

   // Five 32-bit words: the working variables or the chaining value.
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
   } vars_type;

   typedef struct packed {
      logic shift_in;   // a message word beat is being stored
      logic step;       // one round of the compression is running
   } sched_ctl_type;

   typedef struct packed {
      logic init;       // load the working variables from the chaining value
      logic step;       // advance the working variables by one round
   } round_ctl_type;

   localparam vars_type IV = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D, e: IV_E};

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [4:0] n);
      logic [5:0] rn;
      rn = 6'd32 - {1'b0, n};
      return (x << n) | (x >> rn);
   endfunction

endpackage

### rtl/core/sha1_sched.sv
// Message schedule: a sixteen-word shift line that first collects the block
// and then produces one schedule word per round. Depends on sha1_pkg.
module sha1_sched (
   input  logic                      clock,
   input  sha1_pkg::sched_ctl_type   ctl,
   input  logic [31:0]               word_in,
   output logic [31:0]               w_out
);
   import sha1_pkg::*;

   logic [WORD_W-1:0] win_ff [BLOCK_WORDS];
   logic [WORD_W-1:0] win_in [BLOCK_WORDS];
   logic [WORD_W-1:0] feed;

   // Oldest word sits at the bottom; the head of the line is the word of
   // the current round.
   assign w_out = win_ff[0];

   always_comb begin
      feed = word_in;
      if (ctl.step) begin
         feed = rotl(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0], 5'd1);
      end
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[BLOCK_WORDS-1] = feed;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_in || ctl.step) begin
         win_ff <= win_in;
      end
   end

endmodule

### rtl/core/sha1_round.sv
// The shared SHA-1 round unit with its working-variable registers.
// One round per cycle while stepping. Depends on sha1_pkg.
module sha1_round (
   input  logic                    clock,
   input  sha1_pkg::round_ctl_type ctl,
   input  sha1_pkg::vars_type      chain,
   input  logic [31:0]             w,
   input  logic [6:0]              round_idx,
   output sha1_pkg::vars_type      vars
);
   import sha1_pkg::*;

   localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

   vars_type          vars_ff;
   vars_type          vars_in;
   logic [WORD_W-1:0] f;
   logic [WORD_W-1:0] k;
   logic [WORD_W-1:0] tmp;

   assign vars = vars_ff;

   always_comb begin
      if (round_idx < ROUND_W'(20)) begin
         f = (vars_ff.b & vars_ff.c) | (~vars_ff.b & vars_ff.d);
         k = K0;
      end else if (round_idx < ROUND_W'(40)) begin
         f = vars_ff.b ^ vars_ff.c ^ vars_ff.d;
         k = K1;
      end else if (round_idx < ROUND_W'(60)) begin
         f = (vars_ff.b & vars_ff.c) | (vars_ff.b & vars_ff.d) | (vars_ff.c & vars_ff.d);
         k = K2;
      end else begin
         f = vars_ff.b ^ vars_ff.c ^ vars_ff.d;
         k = K3;
      end
      tmp = rotl(vars_ff.a, 5'd5) + f + vars_ff.e + k + w;

      vars_in.a = tmp;
      vars_in.b = vars_ff.a;
      vars_in.c = rotl(vars_ff.b, 5'd30);
      vars_in.d = vars_ff.c;
      vars_in.e = vars_ff.d;
   end

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         vars_ff <= chain;
      end else if (ctl.step) begin
         vars_ff <= vars_in;
      end
   end

endmodule

### rtl/core/sha1_block_hash.sv
// SHA-1 hasher for a message that the host has already padded. Each request
// beat carries one 32-bit message word, first byte in the most significant
// position; sixteen beats make one 512-bit block. Words are taken one per
// cycle until the sixteenth, after which the block is compressed by a single
// round unit at one round per cycle through all 80 rounds, and an add step
// then adds the working variables into the chaining value. req_stall stays
// high throughout the rounds and the add step, so no word of the next block
// is taken before the current block is done. When final_word is set on the
// sixteenth word of a block, the five digest words are presented as one
// response beat and the chaining value returns to the standard initial
// value, so the next word starts a new message; final_word on any other word
// is ignored. A finished digest waits in the response register while the
// next message is being loaded, and the core only holds in its add step if a
// second digest is ready before the first has been taken. Depends on
// sha1_pkg, sha1_sched and sha1_round.
module sha1_block_hash (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  sha1_pkg::req_type req_data,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sha1_pkg::rsp_type rsp_data
);
   import sha1_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_ADD
   } state_type;

   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
   localparam logic [WIDX_W-1:0]  LAST_WORD  = WIDX_W'(BLOCK_WORDS - 1);

   state_type           state_ff;
   logic [ROUND_W-1:0]  round_ff;
   logic [WIDX_W-1:0]   word_idx_ff;
   logic                last_ff;
   vars_type            chain_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                req_fire;
   logic                rsp_free;
   logic                block_done;
   vars_type            sum;
   vars_type            vars;
   logic [WORD_W-1:0]   w;
   sched_ctl_type       sched_ctl;
   round_ctl_type       round_ctl;

   // Words are only taken while the block is being collected.
   assign req_stall  = (state_ff != ST_LOAD);
   assign req_fire   = req_valid && !req_stall;
   assign block_done = req_fire && (word_idx_ff == LAST_WORD);

   // The response register can take a new digest if it is empty or is being
   // emptied in this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign sched_ctl.shift_in = req_fire;
   assign sched_ctl.step     = (state_ff == ST_ROUND);
   assign round_ctl.init     = block_done;
   assign round_ctl.step     = (state_ff == ST_ROUND);

   sha1_sched u_sched (
      .clock   (clock),
      .ctl     (sched_ctl),
      .word_in (req_data.message_word),
      .w_out   (w)
   );

   sha1_round u_round (
      .clock     (clock),
      .ctl       (round_ctl),
      .chain     (chain_ff),
      .w         (w),
      .round_idx (round_ff),
      .vars      (vars)
   );

   // Fold the compressed block into the chaining value.
   always_comb begin
      sum.a = chain_ff.a + vars.a;
      sum.b = chain_ff.b + vars.b;
      sum.c = chain_ff.c + vars.c;
      sum.d = chain_ff.d + vars.d;
      sum.e = chain_ff.e + vars.e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         round_ff     <= '0;
         word_idx_ff  <= '0;
         last_ff      <= 1'b0;
         chain_ff     <= IV;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  word_idx_ff <= word_idx_ff + 1'b1;
               end
               if (block_done) begin
                  last_ff  <= req_data.final_word;
                  round_ff <= '0;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + 1'b1;
               if (round_ff == LAST_ROUND) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               if (!last_ff) begin
                  chain_ff <= sum;
                  state_ff <= ST_LOAD;
               end else if (rsp_free) begin
                  // Final block: publish the digest and start a fresh message.
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.digest_a <= sum.a;
                  rsp_data_ff.digest_b <= sum.b;
                  rsp_data_ff.digest_c <= sum.c;
                  rsp_data_ff.digest_d <= sum.d;
                  rsp_data_ff.digest_e <= sum.e;
                  chain_ff             <= IV;
                  state_ff             <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // The round counter never runs past the last round.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= LAST_ROUND))
      else $error("round counter beyond last round");

   // Compression begins only once a whole block has been collected.
   a_block_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && $past(state_ff) == ST_LOAD) |-> (word_idx_ff == '0))
      else $error("compression started on a partial block");

   // The add step is reached only after all 80 rounds.
   a_all_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && $past(state_ff) != ST_ADD) |-> ($past(round_ff) == LAST_ROUND))
      else $error("chaining add reached early");

   // A digest appears only from the add step of a final block.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ADD && $past(last_ff)))
      else $error("digest beat without a final block");

endmodule

### tb/sha1_block_hash_tb.sv
// Self-checking testbench for the SHA-1 block hasher sha1_block_hash.
// Holds its own SHA-1 predictor in a small scoreboard class and drives the
// block through plain tasks; depends on sha1_pkg and the RTL only.
`timescale 1ns / 1ps

module sha1_block_hash_tb;
   import sha1_pkg::*;

   // Scoreboard: a bit-level SHA-1 predictor that sees every accepted word
   // beat and keeps the digests that the block owes us, oldest first.
   class sha1_scoreboard;
      logic [31:0] hash_state [5];
      logic [31:0] sched_words [16];
      logic [3:0]  fill_pos;
      rsp_type     digests_due [$];
      int unsigned errors;
      int unsigned digests_checked;

      function new();
         restart_chain();
         fill_pos        = 4'd0;
         errors          = 0;
         digests_checked = 0;
      endfunction

      function void restart_chain();
         hash_state[0] = IV_A;
         hash_state[1] = IV_B;
         hash_state[2] = IV_C;
         hash_state[3] = IV_D;
         hash_state[4] = IV_E;
      endfunction

      function logic [31:0] rotate_left(logic [31:0] x, int unsigned n);
         return (x << n) | (x >> (32 - n));
      endfunction

      // Eighty rounds over the sixteen stored words, schedule rolled in place.
      function void fold_block();
         logic [31:0] a, b, c, d, e, f, k, w, t;
         int r;
         a = hash_state[0];
         b = hash_state[1];
         c = hash_state[2];
         d = hash_state[3];
         e = hash_state[4];
         for (r = 0; r < 80; r++) begin
            if (r < 16) begin
               w = sched_words[r];
            end else begin
               w = rotate_left(sched_words[(r + 13) % 16] ^ sched_words[(r + 8) % 16] ^
                               sched_words[(r + 2) % 16] ^ sched_words[r % 16], 1);
               sched_words[r % 16] = w;
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = 32'h5A827999;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = 32'h6ED9EBA1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d;
               k = 32'hCA62C1D6;
            end
            t = rotate_left(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
         end
         hash_state[0] += a;
         hash_state[1] += b;
         hash_state[2] += c;
         hash_state[3] += d;
         hash_state[4] += e;
      endfunction

      // Called for every accepted request beat.
      function void note_word(req_type beat);
         sched_words[fill_pos] = beat.message_word;
         fill_pos = fill_pos + 4'd1;
         if (fill_pos == 4'd0) begin
            fold_block();
            if (beat.final_word) begin
               digests_due.push_back(rsp_type'{digest_a: hash_state[0],
                                               digest_b: hash_state[1],
                                               digest_c: hash_state[2],
                                               digest_d: hash_state[3],
                                               digest_e: hash_state[4]});
               restart_chain();
            end
         end
      endfunction

      // Called for every accepted response beat.
      function void check_digest(rsp_type got);
         rsp_type     want;
         logic [31:0] want_w [5];
         logic [31:0] got_w [5];
         string       tag [5];
         int          i;
         tag = '{"digest_a", "digest_b", "digest_c", "digest_d", "digest_e"};
         if (digests_due.size() == 0) begin
            $display("%0t: digest beat with none outstanding: expected nothing, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want   = digests_due.pop_front();
         want_w = '{want.digest_a, want.digest_b, want.digest_c, want.digest_d, want.digest_e};
         got_w  = '{got.digest_a, got.digest_b, got.digest_c, got.digest_d, got.digest_e};
         for (i = 0; i < 5; i++) begin
            if (got_w[i] !== want_w[i]) begin
               $display("%0t: %s mismatch: expected %h, actual %h",
                        $time, tag[i], want_w[i], got_w[i]);
               errors++;
            end
         end
         digests_checked++;
      endfunction

      function void flag_leftovers();
         if (digests_due.size() != 0) begin
            $display("%0t: %0d digest(s) never arrived: expected %h first, actual none",
                     $time, digests_due.size(), digests_due[0]);
            errors += digests_due.size();
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sha1_scoreboard sb;

   // Idling levels in percent, changed by the stimulus between phases.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // Position of the next word within its block, as the sender sees it.
   logic [3:0]  stream_pos;
   int unsigned words_sent;
   int unsigned stray_flags;
   int unsigned dropped_finals;

   sha1_block_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run. A correct run needs a small fraction of this even
   // with every block waiting on the longest stalls.
   initial begin
      #1_000_000;
      $display("%0t: run timed out", $time);
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: sample the handshake at each rising edge, where both
   // rsp_valid and our own rsp_stall still hold their pre-edge values, then
   // choose the stall for the next cycle.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            sb.check_digest(rsp_data);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Word generator biased towards the extremes: all zeros, all ones and
   // single set bits turn up far more often than uniform values would give.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Offers one beat, with random idle cycles beforehand, and returns in the
   // time step of the edge at which it was accepted. Valid is left high so
   // that back-to-back beats need no second assignment in one step.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      sb.note_word(beat);
      stream_pos = stream_pos + 4'd1;
      words_sent++;
   endtask

   // One message of whole blocks with random content. Inner words carry a
   // stray final flag now and then, which the block must ignore. Once in a
   // while the flag on the closing word is dropped, so the message runs on
   // into the next one without a digest.
   task automatic send_message(input int unsigned n_blocks);
      req_type     beat;
      int unsigned blk;
      logic        closing;
      for (blk = 0; blk < n_blocks; blk++) begin
         do begin
            closing           = (stream_pos == 4'd15);
            beat.message_word = pick_word();
            if (closing) begin
               beat.final_word = (blk == n_blocks - 1) && ($urandom_range(19) != 0);
               if (blk == n_blocks - 1 && !beat.final_word) dropped_finals++;
            end else begin
               beat.final_word = ($urandom_range(9) == 0);
               if (beat.final_word) stray_flags++;
            end
            send_beat(beat);
         end while (!closing);
      end
   endtask

   // One idling phase of roughly n_words beats, always ending on a block
   // boundary. The sender then holds off until every digest owed has come
   // back, so that the block also sees a quiet input while it drains. At
   // least one edge passes here, so valid is never assigned twice in a step.
   task automatic run_phase(input int unsigned n_words, input int unsigned idle_pct,
                            input int unsigned stall_pct);
      int unsigned stop_at;
      int unsigned n_blocks;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = words_sent + n_words;
      while (words_sent < stop_at) begin
         n_blocks = ($urandom_range(3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
         send_message(n_blocks);
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.digests_due.size() != 0);
   endtask

   // The padded one-block message "abc": the only non-zero words are the
   // three letters with the pad bit, and the bit length 24 in the last word.
   function automatic logic [31:0] abc_word(input int unsigned idx);
      if (idx == 0) return 32'h6162_6380;
      if (idx == 15) return 32'h0000_0018;
      return 32'h0000_0000;
   endfunction

   initial begin
      req_type     beat;
      int unsigned i;

      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stream_pos     = 4'd0;
      words_sent     = 0;
      stray_flags    = 0;
      dropped_finals = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, with no idling. First the "abc" block, with a stray
      // final flag on its sixth word that must not cut the block short; the
      // digest is due only on the sixteenth word.
      for (i = 0; i < 16; i++) begin
         beat.message_word = abc_word(i);
         beat.final_word   = (i == 5) || (i == 15);
         send_beat(beat);
      end
      // Then half a block of all-ones words, each flagged as final. None of
      // these flags may count; the random part completes the block.
      for (i = 0; i < 8; i++) begin
         beat.message_word = 32'hFFFF_FFFF;
         beat.final_word   = 1'b1;
         send_beat(beat);
      end
      stray_flags += 9;

      // Random phases: no idling, sender idle, receiver stalling, then both,
      // and a last stretch without idling.
      run_phase(330, 0, 0);
      run_phase(330, 46, 0);
      run_phase(330, 0, 46);
      run_phase(330, 19, 19);
      run_phase(300, 0, 0);

      // Everything owed has arrived; give the block time for a full block of
      // compression in case it produces a beat it should not.
      recv_stall_pct = 0;
      repeat (200) @(posedge clock);
      sb.flag_leftovers();

      $display("Sent %0d message words (%0d stray final flags, %0d dropped message ends).",
               words_sent, stray_flags, dropped_finals);
      $display("Checked %0d digests across five idling phases.", sb.digests_checked);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
